/* rtl/rc5_pkg.sv */
// Package with shared types and constants for the RC5-16 block cipher.
`timescale 1ns / 1ps
package rc5_pkg;
  localparam logic [15:0] MAGIC_P = 16'hB7E1;
  localparam logic [15:0] MAGIC_Q = 16'h9E37;
  localparam int MIX_FACTOR = 3;
  localparam logic CFG_KEY_LOW = 1'b0;
  localparam logic CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic        valid;
    logic        mode;
    logic [15:0] a;
    logic [15:0] b;
  } item_t;

  function automatic logic [15:0] rotl16(input logic [15:0] x, input logic [3:0] s);
    logic [31:0] d;
    d = {x, x} << s;
    return d[31:16];
  endfunction

  function automatic logic [15:0] rotr16(input logic [15:0] x, input logic [3:0] s);
    logic [31:0] d;
    d = {x, x} >> s;
    return d[15:0];
  endfunction
endpackage

/* rtl/rc5_round_cell.sv */
// One round cell of the RC5 chain: a registered half-round pair in either direction.
`timescale 1ns / 1ps
module rc5_round_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  rc5_pkg::item_t  item_in,
  input  logic [15:0]     key_even,
  input  logic [15:0]     key_odd,
  output rc5_pkg::item_t  item_out
);
  rc5_pkg::item_t item_next;
  logic [15:0] ea, eb, db, da;

  always_comb begin
    ea = rc5_pkg::rotl16(item_in.a ^ item_in.b, item_in.b[3:0]) + key_even;
    eb = rc5_pkg::rotl16(item_in.b ^ ea, ea[3:0]) + key_odd;
    db = rc5_pkg::rotr16(item_in.b - key_odd, item_in.a[3:0]) ^ item_in.a;
    da = rc5_pkg::rotr16(item_in.a - key_even, db[3:0]) ^ db;
    item_next = item_in;
    if (item_in.mode) begin
      item_next.a = da;
      item_next.b = db;
    end else begin
      item_next.a = ea;
      item_next.b = eb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (advance) begin
      item_out.valid <= item_in.valid;
    end
    if (advance) begin
      item_out.mode <= item_next.mode;
      item_out.a    <= item_next.a;
      item_out.b    <= item_next.b;
    end
  end
endmodule

/* rtl/rc5_key_sched.sv */
// RC5 key expansion: one mixing step per cycle into the subkey table registers.
`timescale 1ns / 1ps
module rc5_key_sched #(
  parameter int ROUNDS = 12,
  parameter int KEY_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [63:0]                     key_low,
  input  logic [63:0]                     key_high,
  output logic                            busy,
  output logic [2*(ROUNDS+1)-1:0][15:0]   subkeys
);
  localparam int T = 2 * (ROUNDS + 1);
  localparam int C = ((KEY_BYTES + 1) / 2 > 0) ? (KEY_BYTES + 1) / 2 : 1;
  localparam int N = rc5_pkg::MIX_FACTOR * ((T > C) ? T : C);
  localparam int TW = $clog2(T);
  localparam int CW = (C > 1) ? $clog2(C) : 1;
  localparam int NW = $clog2(N + 1);

  logic [C-1:0][15:0] lw;
  logic [TW-1:0] i;
  logic [CW-1:0] j;
  logic [NW-1:0] cnt;
  logic [15:0] a, b;
  logic [15:0] a_next, b_next, sum_b;
  logic [127:0] key_all;
  logic [C-1:0][15:0] lw_init;

  always_comb begin
    key_all = {key_high, key_low};
    lw_init = '0;
    for (int w = 0; w < C; w++) begin
      if (2 * w < KEY_BYTES) lw_init[w][7:0] = key_all[16*w +: 8];
      if (2 * w + 1 < KEY_BYTES) lw_init[w][15:8] = key_all[16*w+8 +: 8];
    end
    a_next = rc5_pkg::rotl16(subkeys[i] + a + b, 4'd3);
    sum_b = lw[j] + a_next + b;
    b_next = rc5_pkg::rotl16(sum_b, 4'(a_next + b));
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      cnt  <= '0;
      i    <= '0;
      j    <= '0;
      a    <= '0;
      b    <= '0;
      lw   <= lw_init;
      for (int k = 0; k < T; k++) begin
        subkeys[k] <= rc5_pkg::MAGIC_P + 16'(k) * rc5_pkg::MAGIC_Q;
      end
    end else if (busy) begin
      subkeys[i] <= a_next;
      lw[j] <= b_next;
      a <= a_next;
      b <= b_next;
      i <= (i == TW'(T - 1)) ? '0 : i + 1'b1;
      j <= (j == CW'(C - 1)) ? '0 : j + 1'b1;
      cnt <= cnt + 1'b1;
      if (cnt == NW'(N - 1)) busy <= 1'b0;
    end
  end
endmodule

/* rtl/rc5_block_cipher_top.sv */
// Top level of the RC5-16 block cipher: key registers, key expansion and the round chain.
`timescale 1ns / 1ps
// Usage: write key_low (index 0) and key_high (index 1) through cfg_we/cfg_index/cfg_data
// while the block is idle. Every valid write restarts the subkey expansion from the newly
// written key; reset runs the same expansion from the all-zero key. No request is taken
// while it runs.
// Requests arrive on in_valid/in_stall with mode (0 encrypt, 1 decrypt) and block_in.
// Each request walks a chain of ROUNDS+2 register cells: an input cell that adds the
// whitening subkeys on encryption, ROUNDS round cells, and an output cell that strips them
// on decryption. Encryption walks the cells forward and decryption walks the same chain
// with subkeys in reverse round order. Each request is registered in every cell in turn,
// and one request can enter every cycle unless the chain holds or key expansion runs.
// Results leave on out_valid/out_stall with block_out. When the receiver stalls while the
// last cell holds a result, the whole chain holds and in_stall rises in the same cycle.
// Reset clears every valid bit in the chain and starts key expansion.
module rc5_block_cipher_top #(
  parameter int ROUNDS = 12,
  parameter int KEY_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] block_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] block_out
);
  localparam int T = 2 * (ROUNDS + 1);

  logic [63:0] key_low, key_high;
  logic [63:0] key_low_next, key_high_next;
  logic busy, advance;
  logic [T-1:0][15:0] subkeys;
  rc5_pkg::item_t chain [ROUNDS+2];
  rc5_pkg::item_t head;

  // The expansion starts at the write edge, so it is fed the key as it will be after it.
  always_comb begin
    key_low_next  = key_low;
    key_high_next = key_high;
    if (rst) begin
      key_low_next  = '0;
      key_high_next = '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rc5_pkg::CFG_KEY_LOW:  key_low_next  = cfg_data;
        rc5_pkg::CFG_KEY_HIGH: key_high_next = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else begin
      key_low  <= key_low_next;
      key_high <= key_high_next;
    end
  end

  rc5_key_sched #(.ROUNDS(ROUNDS), .KEY_BYTES(KEY_BYTES)) u_sched (
    .clk(clk), .rst(rst), .start(cfg_we), .key_low(key_low_next), .key_high(key_high_next),
    .busy(busy), .subkeys(subkeys)
  );

  // The chain moves as one unit; it holds only when the final result is stuck.
  assign advance  = !(chain[ROUNDS+1].valid && out_stall);
  assign in_stall = !advance || busy;

  // Input cell: encryption adds the whitening keys here; decryption passes through.
  always_comb begin
    head.valid = in_valid && !busy;
    head.mode  = mode;
    head.a     = mode ? block_in[15:0]  : block_in[15:0]  + subkeys[0];
    head.b     = mode ? block_in[31:16] : block_in[31:16] + subkeys[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (advance) begin
      chain[0].valid <= head.valid;
    end
    if (advance) begin
      chain[0].mode <= head.mode;
      chain[0].a    <= head.a;
      chain[0].b    <= head.b;
    end
  end

  for (genvar r = 1; r <= ROUNDS; r++) begin : g_round
    logic [15:0] ke, ko;
    // Cell r runs round r forward or round ROUNDS+1-r backward.
    assign ke = chain[r-1].mode ? subkeys[2*(ROUNDS+1-r)]   : subkeys[2*r];
    assign ko = chain[r-1].mode ? subkeys[2*(ROUNDS+1-r)+1] : subkeys[2*r+1];
    rc5_round_cell u_cell (
      .clk(clk), .rst(rst), .advance(advance), .item_in(chain[r-1]),
      .key_even(ke), .key_odd(ko), .item_out(chain[r])
    );
  end

  // Output cell: decryption strips the whitening keys here.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[ROUNDS+1].valid <= 1'b0;
    end else if (advance) begin
      chain[ROUNDS+1].valid <= chain[ROUNDS].valid;
    end
    if (advance) begin
      chain[ROUNDS+1].mode <= chain[ROUNDS].mode;
      chain[ROUNDS+1].a <= chain[ROUNDS].mode ? chain[ROUNDS].a - subkeys[0]
                                              : chain[ROUNDS].a;
      chain[ROUNDS+1].b <= chain[ROUNDS].mode ? chain[ROUNDS].b - subkeys[1]
                                              : chain[ROUNDS].b;
    end
  end

  assign out_valid = chain[ROUNDS+1].valid;
  assign block_out = {chain[ROUNDS+1].b, chain[ROUNDS+1].a};
endmodule

/* dv/tb_rc5_block_cipher_top.sv */
// Self-checking testbench for the RC5-16 block cipher top level.
`timescale 1ns / 1ps
module tb_rc5_block_cipher_top;

  localparam int ROUNDS = 12;
  localparam int KEY_BYTES = 16;
  localparam int TABLE_LEN = 2 * (ROUNDS + 1);
  localparam int KEY_WORDS = (KEY_BYTES + 1) / 2 > 0 ? (KEY_BYTES + 1) / 2 : 1;
  localparam int EXPAND_CYCLES = 3 * (TABLE_LEN > KEY_WORDS ? TABLE_LEN : KEY_WORDS);
  localparam int CHAIN_LATENCY = ROUNDS + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] block;
  } cipher_req_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [31:0] block_in;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] block_out;

  rc5_block_cipher_top #(.ROUNDS(ROUNDS), .KEY_BYTES(KEY_BYTES)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .block_in(block_in),
    .out_valid(out_valid), .out_stall(out_stall), .block_out(block_out)
  );

  // Testbench copy of the key registers and the expanded subkeys.
  logic [63:0] key_lo_shadow;
  logic [63:0] key_hi_shadow;
  logic [15:0] subkeys [TABLE_LEN];

  cipher_req_t pending_reqs[$];    // requests waiting for the driver
  logic [31:0] expected_blocks[$]; // predicted ciphertexts and plaintexts
  int  mismatches;
  int  cycle_count;
  bit  allow_idle;                 // random gaps on both sides while set
  int  send_gap;
  int  stall_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] rot_left(logic [15:0] x, logic [15:0] n);
    logic [3:0] s;
    s = n[3:0];
    return (s == 0) ? x : ((x << s) | (x >> (16 - s)));
  endfunction

  function automatic logic [15:0] rot_right(logic [15:0] x, logic [15:0] n);
    logic [3:0] s;
    s = n[3:0];
    return (s == 0) ? x : ((x >> s) | (x << (16 - s)));
  endfunction

  function automatic logic [7:0] key_byte(int k);
    if (k < 8) return key_lo_shadow[8*k +: 8];
    if (k < 16) return key_hi_shadow[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  // Standard RC5 key schedule, run whenever a key register changes.
  task automatic expand_subkeys();
    logic [15:0] kw [KEY_WORDS];
    logic [15:0] a;
    logic [15:0] b;
    int i;
    int j;
    a = '0;
    b = '0;
    i = 0;
    j = 0;
    for (int w = 0; w < KEY_WORDS; w++) kw[w] = '0;
    for (int idx = KEY_BYTES - 1; idx >= 0; idx--)
      kw[(idx / 2) % KEY_WORDS] = (kw[(idx / 2) % KEY_WORDS] << 8) + key_byte(idx);
    subkeys[0] = rc5_pkg::MAGIC_P;
    for (int k = 1; k < TABLE_LEN; k++) subkeys[k] = subkeys[k-1] + rc5_pkg::MAGIC_Q;
    for (int k = 0; k < EXPAND_CYCLES; k++) begin
      a = rot_left(subkeys[i] + a + b, 16'd3);
      subkeys[i] = a;
      b = rot_left(kw[j] + a + b, a + b);
      kw[j] = b;
      i = (i + 1) % TABLE_LEN;
      j = (j + 1) % KEY_WORDS;
    end
  endtask

  function automatic logic [31:0] cipher_block(cipher_req_t r);
    logic [15:0] a;
    logic [15:0] b;
    a = r.block[15:0];
    b = r.block[31:16];
    if (r.mode == MODE_ENC) begin
      a = a + subkeys[0];
      b = b + subkeys[1];
      for (int k = 1; k <= ROUNDS; k++) begin
        a = rot_left(a ^ b, b) + subkeys[2*k];
        b = rot_left(b ^ a, a) + subkeys[2*k+1];
      end
    end else begin
      for (int k = ROUNDS; k >= 1; k--) begin
        b = rot_right(b - subkeys[2*k+1], a) ^ a;
        a = rot_right(a - subkeys[2*k], b) ^ b;
      end
      b = b - subkeys[1];
      a = a - subkeys[0];
    end
    return {b, a};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Driver: one request per accepted handshake, with random bursts of idle cycles.
  // The prediction is made when the request is accepted, with the key then in force.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_blocks.push_back(cipher_block('{mode: mode, block: block_in}));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          cipher_req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          mode <= r.mode;
          block_in <= r.block;
          if (allow_idle && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // stalls the output at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0)
          report_mismatch("unexpected result", block_out, 32'h0);
        else begin
          logic [31:0] want;
          want = expected_blocks.pop_front();
          if (block_out !== want) report_mismatch("block_out", block_out, want);
        end
      end
      if (stall_gap > 0) begin
        out_stall <= 1'b1;
        stall_gap <= stall_gap - 1;
      end else if (allow_idle && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        stall_gap <= $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Writes one key register and refreshes the predicted subkeys.
  task automatic write_key(logic idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rc5_pkg::CFG_KEY_LOW) key_lo_shadow = value;
    else key_hi_shadow = value;
    expand_subkeys();
  endtask

  // Waits until every queued request is sent and every result checked, then
  // leaves room for the chain to empty.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_blocks.size() > 0 || in_valid)
      @(posedge clk);
    repeat (CHAIN_LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_block();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return {16'hffff, 16'h0000};
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_random(int count);
    cipher_req_t r;
    for (int k = 0; k < count; k++) begin
      r.mode = 1'($urandom_range(0, 1));
      r.block = rand_block();
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    logic [63:0] key_settings [6];
    cipher_req_t r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = rc5_pkg::CFG_KEY_LOW;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_ENC;
    block_in = '0;
    out_stall = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    allow_idle = 1'b0;
    key_lo_shadow = '0;
    key_hi_shadow = '0;
    expand_subkeys();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the all-zero key: field extremes in both modes and
    // single bits walking through the block.
    for (int m = 0; m < 2; m++) begin
      r.mode = m[0];
      r.block = 32'h0000_0000; pending_reqs.push_back(r);
      r.block = 32'hffff_ffff; pending_reqs.push_back(r);
      r.block = 32'h0000_ffff; pending_reqs.push_back(r);
      r.block = 32'hffff_0000; pending_reqs.push_back(r);
      r.block = 32'h5555_aaaa; pending_reqs.push_back(r);
      for (int k = 0; k < 32; k += 5) begin
        r.block = 32'h1 << k;
        pending_reqs.push_back(r);
      end
    end
    drain();

    // Several keys, extremes first; each register is written in every phase.
    key_settings[0] = 64'hffff_ffff_ffff_ffff;
    key_settings[1] = 64'h0000_0000_0000_0000;
    key_settings[2] = 64'h0123_4567_89ab_cdef;
    key_settings[3] = {$urandom(), $urandom()};
    key_settings[4] = {$urandom(), $urandom()};
    key_settings[5] = {$urandom(), $urandom()};
    for (int phase = 0; phase < 6; phase++) begin
      write_key(rc5_pkg::CFG_KEY_LOW, key_settings[phase]);
      write_key(rc5_pkg::CFG_KEY_HIGH,
                phase == 1 ? 64'hffff_ffff_ffff_ffff : ~key_settings[phase]);
      allow_idle = (phase < 5);
      queue_random(phase == 5 ? 150 : 250);
      drain();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/rc5_pkg.sv
rtl/rc5_round_cell.sv
rtl/rc5_key_sched.sv
rtl/rc5_block_cipher_top.sv
dv/tb_rc5_block_cipher_top.sv
